// ----- rtl/core/tcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// tcbd_pkg - shared types and constants of the terminal control byte decoder
// Screen geometry, action codes, host control bytes, beat structs and the
// constant tables for the modulo reduction of host cursor position bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcbd_pkg;

  // Screen geometry
  localparam int SCREEN_ROWS = 24;
  localparam int SCREEN_COLS = 80;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ACT_W  = 3;
  localparam int POS_W  = 8;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ACT_W-1:0]  act_t;

  localparam pos_t LAST_ROW = pos_t'(SCREEN_ROWS - 1);
  localparam pos_t LAST_COL = pos_t'(SCREEN_COLS - 1);

  // Action codes
  localparam act_t ACT_DISPLAY  = 3'd0;
  localparam act_t ACT_MOVE     = 3'd1;
  localparam act_t ACT_HOSTPOS  = 3'd2;
  localparam act_t ACT_CLEAR    = 3'd3;
  localparam act_t ACT_CLEARALL = 3'd4;
  localparam act_t ACT_BELL     = 3'd5;
  localparam act_t ACT_CHARTYPE = 3'd6;

  // Host control bytes
  localparam byte_t CH_HOME    = 8'd2;
  localparam byte_t CH_CLEAR   = 8'd6;
  localparam byte_t CH_BELL    = 8'd7;
  localparam byte_t CH_BS      = 8'd8;
  localparam byte_t CH_LF      = 8'd10;
  localparam byte_t CH_CLRALL  = 8'd12;
  localparam byte_t CH_CR      = 8'd13;
  localparam byte_t CH_HOSTPOS = 8'd16;
  localparam byte_t CH_UP      = 8'd23;
  localparam byte_t CH_RIGHT   = 8'd24;
  localparam byte_t CH_LEFT    = 8'd25;
  localparam byte_t CH_DOWN    = 8'd26;
  localparam byte_t CH_PROT_ON = 8'd28;
  localparam byte_t CH_PROT_OFF = 8'd29;
  localparam byte_t CH_SPACE   = 8'd32;
  localparam byte_t CH_DEL     = 8'd127;

  // Host position sequence states
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ROW  = 2'd1;
  localparam logic [1:0] PEND_COL  = 2'd2;

  typedef struct packed {
    byte_t            data_byte;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
  } in_item_t;

  typedef struct packed {
    act_t             action;
    byte_t            char_code;
    logic [ROW_W-1:0] target_row;
    logic [COL_W-1:0] target_col;
    logic             last;
  } res_t;

  // Decode of the held item: result count and first result
  typedef struct packed {
    logic [1:0] nres;
    res_t       first;
  } dec_t;

  // Output stage status back to the top level
  typedef struct packed {
    logic load;
    logic done;
  } out_stat_t;

  // Second result of a newline
  localparam res_t NL_CR_RES = '{ACT_DISPLAY, CH_CR, '0, '0, 1'b1};

  localparam int TAB_N = 1 << BYTE_W;
  typedef pos_t mod_tab_t [TAB_N];

  function automatic mod_tab_t make_row_tab();
    mod_tab_t t;
    for (int i = 0; i < TAB_N; i++) begin
      t[i] = pos_t'(i % SCREEN_ROWS);
    end
    return t;
  endfunction

  function automatic mod_tab_t make_col_tab();
    mod_tab_t t;
    for (int i = 0; i < TAB_N; i++) begin
      t[i] = pos_t'(i % SCREEN_COLS);
    end
    return t;
  endfunction

  localparam mod_tab_t ROW_MOD_TAB = make_row_tab();
  localparam mod_tab_t COL_MOD_TAB = make_col_tab();

endpackage

`default_nettype wire

// ----- rtl/core/tcbd_if.sv -----
// ----------------------------------------------------------------------------
// tcbd_if - valid/ready channels of the terminal control byte decoder
// Input channel carries host bytes with cursor position, output channel
// carries display actions.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;

  modport source (output valid, data_byte, cursor_row, cursor_col, input ready);
  modport sink   (input valid, data_byte, cursor_row, cursor_col, output ready);
endinterface

interface tcbd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] char_code;
  logic [4:0] target_row;
  logic [6:0] target_col;
  logic       last;

  modport source (output valid, action, char_code, target_row, target_col, last,
                  input ready);
  modport sink   (input valid, action, char_code, target_row, target_col, last,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tcbd_decode.sv -----
// ----------------------------------------------------------------------------
// tcbd_decode - byte decode and host position sequence state
// Decodes the held byte into a result count and its first result, and
// keeps the host cursor position sequence state across beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbd_decode
  import tcbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t item,
  input  logic     advance,
  output dec_t     dec
);

  logic [1:0] pend_r, pend_nxt;
  byte_t      saved_r, saved_nxt;

  byte_t      b;
  pos_t       row, col, row_up, row_dn;
  act_t       act;
  byte_t      code;
  pos_t       trow, tcol;
  logic       last;
  logic [1:0] nres;

  // Clamp cursor input to the screen
  always_comb begin
    b      = item.data_byte;
    row    = (pos_t'(item.cursor_row) > LAST_ROW) ? LAST_ROW : pos_t'(item.cursor_row);
    col    = (pos_t'(item.cursor_col) > LAST_COL) ? LAST_COL : pos_t'(item.cursor_col);
    row_up = (row == '0) ? LAST_ROW : row - pos_t'(1);
    row_dn = (row >= LAST_ROW) ? '0 : row + pos_t'(1);
  end

  // Decode the byte
  always_comb begin
    nres      = 2'd0;
    act       = ACT_DISPLAY;
    code      = '0;
    trow      = '0;
    tcol      = '0;
    last      = 1'b1;
    pend_nxt  = pend_r;
    saved_nxt = saved_r;
    if (pend_r == PEND_COL) begin
      saved_nxt = b;
      pend_nxt  = PEND_ROW;
    end else if (pend_r != PEND_NONE) begin
      pend_nxt = PEND_NONE;
      nres     = 2'd1;
      act      = ACT_HOSTPOS;
      trow     = ROW_MOD_TAB[b];
      tcol     = COL_MOD_TAB[saved_r];
    end else if (b == CH_DEL) begin
      nres = 2'd0;
    end else if (b >= CH_SPACE) begin
      nres = 2'd1;
      code = b;
    end else begin
      unique case (b) inside
        CH_HOME: begin
          nres = 2'd1;
          act  = ACT_MOVE;
        end
        CH_CLEAR: begin
          nres = 2'd1;
          act  = ACT_CLEAR;
        end
        CH_BELL: begin
          nres = 2'd1;
          act  = ACT_BELL;
        end
        CH_BS, CH_CR: begin
          nres = 2'd1;
          code = b;
        end
        CH_LF: begin
          nres = 2'd2;
          code = CH_LF;
          last = 1'b0;
        end
        CH_CLRALL: begin
          nres = 2'd1;
          act  = ACT_CLEARALL;
        end
        CH_HOSTPOS: begin
          pend_nxt = PEND_COL;
        end
        CH_UP: begin
          nres = 2'd1;
          act  = ACT_MOVE;
          trow = row_up;
          tcol = col;
        end
        CH_RIGHT: begin
          nres = 2'd1;
          act  = ACT_MOVE;
          if (col >= LAST_COL) begin
            trow = row_dn;
            tcol = '0;
          end else begin
            trow = row;
            tcol = col + pos_t'(1);
          end
        end
        CH_LEFT: begin
          nres = 2'd1;
          act  = ACT_MOVE;
          if (col == '0) begin
            trow = row_up;
            tcol = LAST_COL;
          end else begin
            trow = row;
            tcol = col - pos_t'(1);
          end
        end
        CH_DOWN: begin
          nres = 2'd1;
          act  = ACT_MOVE;
          trow = row_dn;
          tcol = col;
        end
        CH_PROT_ON, CH_PROT_OFF: begin
          nres = 2'd1;
          act  = ACT_CHARTYPE;
          code = b;
        end
        default: begin
          nres = 2'd0;
        end
      endcase
    end
  end

  // Mask targets to the output field widths
  assign dec.nres             = nres;
  assign dec.first.action     = act;
  assign dec.first.char_code  = code;
  assign dec.first.target_row = trow[ROW_W-1:0];
  assign dec.first.target_col = tcol[COL_W-1:0];
  assign dec.first.last       = last;

  // Advance sequence state when the held beat retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= PEND_NONE;
      saved_r <= '0;
    end else if (advance) begin
      pend_r  <= pend_nxt;
      saved_r <= saved_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcbd_out.sv -----
// ----------------------------------------------------------------------------
// tcbd_out - result register and result sequencing
// Moves the results of the held item one at a time into the result
// register, and reports when the held item has delivered all of them.
// ----------------------------------------------------------------------------
`default_nettype none

module tcbd_out
  import tcbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      hold_valid,
  input  dec_t      dec,
  input  logic      out_ready,
  output logic      out_valid,
  output res_t      out_res,
  output out_stat_t stat,
  output logic      idx
);

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;
  logic idx_r, idx_nxt;
  res_t sel;

  // Load when a result is pending and the register is free or emptying
  always_comb begin
    sel       = idx_r ? NL_CR_RES : dec.first;
    stat.load = hold_valid && (dec.nres != 2'd0) && (!out_valid_r || out_ready);
    stat.done = hold_valid &&
                ((dec.nres == 2'd0) || (stat.load && (idx_r || dec.nres == 2'd1)));
    idx_nxt   = idx_r;
    if (stat.load) begin
      idx_nxt = idx_r ? 1'b0 : (dec.nres == 2'd2);
    end
    out_valid_nxt = stat.load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (stat.load) begin
      out_res_r <= sel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign idx       = idx_r;

endmodule

`default_nettype wire

// ----- rtl/core/terminal_control_byte_decoder.sv -----
// ----------------------------------------------------------------------------
// terminal_control_byte_decoder - host byte stream to display actions
// Input register, byte decode with host position state, result register.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | beat
//  in_ch    | in  | data_byte, cursor_row, cursor_col               | host byte
//  out_ch   | out | action, char_code, target_row, target_col, last | one result
//
// A byte is taken every cycle unless a result is blocked or a newline is
// held; it passes the input register, then the single result register,
// which takes a newline's two results one at a time. Output stalls back up
// through the input register into in_ch.ready. Synchronous reset clears
// the sequence state and all valid flags; no clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_control_byte_decoder
  import tcbd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  tcbd_in_if.sink       in_ch,
  tcbd_out_if.source    out_ch
);

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  dec_t      dec;
  out_stat_t stat;
  logic      out_valid;
  res_t      out_res;
  logic      idx;
  logic      in_ready;
  logic      in_take;

  // Accept when the held item is absent or retiring
  assign in_ready = !s1_valid_r || stat.done;
  assign in_take  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (stat.done) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{in_ch.data_byte, in_ch.cursor_row, in_ch.cursor_col};
    end
  end

  tcbd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (s1_item_r),
    .advance (stat.done),
    .dec     (dec)
  );

  tcbd_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (s1_valid_r),
    .dec        (dec),
    .out_ready  (out_ch.ready),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .stat       (stat),
    .idx        (idx)
  );

  // Drive the result channel
  assign out_ch.valid      = out_valid;
  assign out_ch.action     = out_res.action;
  assign out_ch.char_code  = out_res.char_code;
  assign out_ch.target_row = out_res.target_row;
  assign out_ch.target_col = out_res.target_col;
  assign out_ch.last       = out_res.last;

  // A non-final result is followed at once by the carriage return
  a_cr_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=>
      out_ch.valid && out_ch.char_code == CH_CR && out_ch.last)
    else $error("carriage return does not follow line feed");

  // Second result index only while a newline is held
  a_idx_newline: assert property (@(posedge clk) disable iff (!rst_n)
    idx |-> s1_valid_r && dec.nres == 2'd2)
    else $error("result index set without a held newline");

  // Back pressure only with a blocked result or a newline loading its first result
  a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r &&
      ((out_ch.valid && !out_ch.ready) || (dec.nres == 2'd2 && !idx)))
    else $error("input stalled without a blocked result");

  // A result is loaded only while an item is held
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    stat.load |-> s1_valid_r)
    else $error("result loaded without a held item");

endmodule

`default_nettype wire
